@@ src/dtps_pkg.sv @@
// Shared types and codes for the depth-tested pixel store.
// Used by the front end, back end, top level and port checker of the block.
package dtps_pkg;

  // operation codes of an input item
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic CFG_ACTIVE_WIDTH  = 1'b0;
  localparam logic CFG_ACTIVE_HEIGHT = 1'b1;

  localparam logic [9:0] DIM_RESET = 10'd512;

  typedef struct packed {
    logic        [1:0]  operation;
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic        [23:0] depth;
    logic        [23:0] color;
  } in_item_t;

  typedef struct packed {
    logic [23:0] read_color;
    logic        written;
    logic        in_range;
  } out_item_t;

  // classified command passed from front end to back end
  typedef struct packed {
    logic [1:0]  operation;
    logic        in_range;
    logic [23:0] depth;
    logic [23:0] color;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOK,
    BK_CLEAR
  } back_state_t;

endpackage

@@ src/dtps_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dtps_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/dtps_front.sv @@
// Front end: accepts items, checks bounds, computes the flipped store address.
// Depends on dtps_pkg.
module dtps_front import dtps_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int AW         = 18
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  in_item_t      item,
  input  logic [9:0]    active_width,
  input  logic [9:0]    active_height,
  output logic          q_push,
  input  logic          q_ready,
  output cmd_t          q_cmd,
  output logic [AW-1:0] q_addr
);

  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int HB = $clog2(MAX_HEIGHT + 1);
  localparam int XB = $clog2(MAX_WIDTH);
  localparam int YB = $clog2(MAX_HEIGHT);

  logic           s1_valid;
  in_item_t       s1;
  logic           s2_valid;
  cmd_t           s2_cmd;
  logic [AW-1:0]  s2_prod;
  logic [XB-1:0]  s2_x;

  logic           s2_ready;
  logic           s1_adv;
  logic           take;
  logic [WB-1:0]  eff_w;
  logic [HB-1:0]  eff_h;
  logic           x_ok;
  logic           y_ok;
  logic [HB-1:0]  row_h;
  logic [YB-1:0]  row;
  logic [YB+WB-1:0] prod;
  cmd_t           cmd;

  assign s2_ready = !s2_valid || q_ready;
  assign s1_adv   = s1_valid && s2_ready;
  assign full     = s1_valid && !s2_ready;
  assign take     = push && !full;

  // dimensions above the store size saturate
  always_comb begin
    eff_w = ({3'b000, active_width} > 13'(MAX_WIDTH)) ? WB'(MAX_WIDTH) : WB'(active_width);
    eff_h = ({3'b000, active_height} > 13'(MAX_HEIGHT)) ? HB'(MAX_HEIGHT)
                                                          : HB'(active_height);
  end

  always_comb begin
    x_ok  = !s1.x[11] && ({1'b0, s1.x[11:0]} < 13'(eff_w));
    y_ok  = !s1.y[11] && ({1'b0, s1.y[11:0]} < 13'(eff_h));
    // image row y is kept at row height-1-y
    row_h = eff_h - HB'(1) - HB'(s1.y[11:0]);
    row   = row_h[YB-1:0];
    prod  = row * eff_w;
    cmd.operation = s1.operation;
    cmd.in_range  = x_ok && y_ok && (s1.operation inside {OP_WRITE, OP_READ});
    cmd.depth     = s1.depth;
    cmd.color     = s1.color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (q_ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1 <= item;
    end
    if (s1_adv) begin
      s2_cmd  <= cmd;
      s2_prod <= AW'(prod);
      s2_x    <= s1.x[XB-1:0];
    end
  end

  assign q_push = s2_valid;
  assign q_cmd  = s2_cmd;
  assign q_addr = s2_prod + AW'(s2_x);

endmodule

@@ src/dtps_queue.sv @@
// Short register FIFO that decouples the front end from the back end.
// No dependencies.
module dtps_queue #(
  parameter int WIDTH = 69,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_pop,
  output logic [WIDTH-1:0] out_data
);

  localparam int PB = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PB-1:0]    wr_ptr;
  logic [PB-1:0]    rd_ptr;
  logic [PB:0]      count;
  logic             do_push;
  logic             do_pop;

  assign in_ready  = (count != (PB+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign do_push   = in_valid && in_ready;
  assign do_pop    = out_pop && out_valid;
  assign out_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PB'(DEPTH - 1)) ? '0 : wr_ptr + PB'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PB'(DEPTH - 1)) ? '0 : rd_ptr + PB'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (PB+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PB+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

@@ src/dtps_back.sv @@
// Back end: depth test and store update, reads, clear sweep, result register.
// Depends on dtps_pkg and dtps_ram.
module dtps_back import dtps_pkg::*; #(
  parameter int AW         = 18,
  parameter int STORE_SIZE = 262144,
  parameter int DEPTH_BITS = 24,
  parameter int COLOR_BITS = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_pop,
  input  cmd_t          q_cmd,
  input  logic [AW-1:0] q_addr,
  input  logic          pop,
  output logic          res_valid,
  output out_item_t     res
);

  localparam int DEXT = (DEPTH_BITS > 24) ? DEPTH_BITS : 24;
  localparam int CEXT = (COLOR_BITS > 24) ? COLOR_BITS : 24;
  localparam int RW   = DEPTH_BITS + COLOR_BITS;

  back_state_t state;
  back_state_t state_next;
  cmd_t        cur;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] cnt;

  logic            slot_free;
  logic            last;
  logic            res_load;
  out_item_t       res_next;
  logic            rd_en;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [RW-1:0]   wr_data;
  logic [RW-1:0]   rd_data;
  logic [DEPTH_BITS-1:0] stored_depth;
  logic [COLOR_BITS-1:0] stored_color;
  logic [DEPTH_BITS-1:0] new_depth;
  logic [COLOR_BITS-1:0] new_color;
  logic            pass;

  assign slot_free    = !res_valid || pop;
  assign last         = (cnt == AW'(STORE_SIZE - 1));
  assign stored_depth = rd_data[RW-1:COLOR_BITS];
  assign stored_color = rd_data[COLOR_BITS-1:0];
  assign new_depth    = DEPTH_BITS'(DEXT'(cur.depth));
  assign new_color    = COLOR_BITS'(CEXT'(cur.color));
  // equal depth overwrites
  assign pass         = !(stored_depth < new_depth);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          case (q_cmd.operation)
            OP_CLEAR: state_next = BK_CLEAR;
            default: begin
              if (q_cmd.in_range) begin
                state_next = BK_LOOK;
              end
            end
          endcase
        end
      end
      BK_LOOK: begin
        if (slot_free) begin
          state_next = BK_IDLE;
        end
      end
      BK_CLEAR: begin
        if (last && slot_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = cur_addr;
    wr_data  = {new_depth, new_color};
    res_load = 1'b0;
    res_next = '0;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          case (q_cmd.operation)
            OP_CLEAR: q_pop = 1'b1;
            default: begin
              if (q_cmd.in_range) begin
                q_pop = 1'b1;
                rd_en = 1'b1;
              end else if (slot_free) begin
                // out of range or unused code: all-zero result
                q_pop    = 1'b1;
                res_load = 1'b1;
              end
            end
          endcase
        end
      end
      BK_LOOK: begin
        if (slot_free) begin
          res_load          = 1'b1;
          res_next.in_range = 1'b1;
          if (cur.operation == OP_WRITE) begin
            wr_en            = pass;
            res_next.written = pass;
          end else begin
            res_next.read_color = 24'(CEXT'(stored_color));
          end
        end
      end
      BK_CLEAR: begin
        wr_addr = cnt;
        wr_data = {{DEPTH_BITS{1'b1}}, new_color};
        // last entry waits for room so the result goes out with it
        if (!last || slot_free) begin
          wr_en = 1'b1;
        end
        res_load = last && slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && q_pop) begin
      cur      <= q_cmd;
      cur_addr <= q_addr;
      cnt      <= '0;
    end else if (state == BK_CLEAR && wr_en) begin
      cnt <= cnt + AW'(1);
    end
    if (res_load) begin
      res <= res_next;
    end
  end

  dtps_ram #(
    .WIDTH (RW),
    .DEPTH (STORE_SIZE)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (q_addr),
    .rd_data (rd_data)
  );

endmodule

@@ src/depth_tested_pixel_store_core.sv @@
// Z-buffered frame store, top level: configuration registers and the
// front end / queue / back end chain. Depends on dtps_pkg and the dtps_* modules.
//
// Items enter through push/full and each gives exactly one result on the
// empty/pop side, in order. A depth-tested write or a read in range holds the
// back end for a registered read of the pixel store, then compare and
// write-back once the result register is free; out-of-range items and unused
// operation codes skip the store. A clear writes one entry per cycle over the
// whole store, MAX_WIDTH*MAX_HEIGHT entries (262144 with the default sizes),
// then returns its result. The front end registers each item and its command,
// and a four-entry queue lets it keep accepting while the back end is busy.
// Store contents are not initialized by reset; issue a clear before use.
module depth_tested_pixel_store_core import dtps_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int DEPTH_BITS = 24,
  parameter int COLOR_BITS = 24
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  in_item_t   item,
  output logic       empty,
  input  logic       pop,
  output out_item_t  result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [9:0] cfg_data
);

  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW         = $clog2(STORE_SIZE);
  localparam int QW         = $bits(cmd_t) + AW;

  logic [9:0]    active_width;
  logic [9:0]    active_height;
  logic          f_push;
  logic          f_ready;
  cmd_t          f_cmd;
  logic [AW-1:0] f_addr;
  logic          q_valid;
  logic          q_pop;
  logic [QW-1:0] q_data;
  logic          res_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width  <= DIM_RESET;
      active_height <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ACTIVE_WIDTH:  active_width  <= cfg_data;
        CFG_ACTIVE_HEIGHT: active_height <= cfg_data;
        default: ;
      endcase
    end
  end

  dtps_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .item          (item),
    .active_width  (active_width),
    .active_height (active_height),
    .q_push        (f_push),
    .q_ready       (f_ready),
    .q_cmd         (f_cmd),
    .q_addr        (f_addr)
  );

  dtps_queue #(
    .WIDTH (QW),
    .DEPTH (4)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_push),
    .in_ready  (f_ready),
    .in_data   ({f_cmd, f_addr}),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_data  (q_data)
  );

  dtps_back #(
    .AW         (AW),
    .STORE_SIZE (STORE_SIZE),
    .DEPTH_BITS (DEPTH_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_data[QW-1:AW]),
    .q_addr    (q_data[AW-1:0]),
    .pop       (pop),
    .res_valid (res_valid),
    .res       (result)
  );

  assign empty = !res_valid;

endmodule

@@ src/dtps_checker.sv @@
// Port-level checker for the depth-tested pixel store, bound to the top level.
// Depends on dtps_pkg.
module dtps_checker import dtps_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      push,
  input logic      full,
  input logic      pop,
  input logic      empty,
  input out_item_t result
);

  logic [4:0] outstanding;

  // items accepted whose result has not been taken yet
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      case ({push && !full, pop && !empty})
        2'b10:   outstanding <= outstanding + 5'd1;
        2'b01:   outstanding <= outstanding - 5'd1;
        default: ;
      endcase
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("ports not idle after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    !empty |-> outstanding != 5'd0)
    else $error("result shown with no item outstanding");

  a_written_in_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.written) |-> (result.in_range && result.read_color == 24'd0))
    else $error("write transfer flagged outside image or with color");

  a_out_of_range_black: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.in_range) |-> (result.read_color == 24'd0 && !result.written))
    else $error("out-of-range result not black");

endmodule

bind depth_tested_pixel_store_core dtps_checker u_dtps_checker (.*);
